/* hw/rtl/totp_pkg.sv */
// Shared types, constants and helpers for the TOTP code check block.
// No dependencies; imported by every module of the block.
package totp_pkg;

    localparam int SecretBytesDef = 20;
    localparam int CfgAddrW       = 3;
    localparam int CfgDataW       = 64;

    // configuration register indexes
    localparam logic [CfgAddrW-1:0] CFG_SECRET_HIGH   = 3'd0;
    localparam logic [CfgAddrW-1:0] CFG_SECRET_MIDDLE = 3'd1;
    localparam logic [CfgAddrW-1:0] CFG_SECRET_LOW    = 3'd2;
    localparam logic [CfgAddrW-1:0] CFG_DIGIT_COUNT   = 3'd3;
    localparam logic [CfgAddrW-1:0] CFG_SKEW_WINDOWS  = 3'd4;

    localparam logic [159:0] ShaIv = {32'h67452301, 32'hefcdab89, 32'h98badcfe,
                                      32'h10325476, 32'hc3d2e1f0};
    localparam logic [31:0] K0 = 32'h5a827999;
    localparam logic [31:0] K1 = 32'h6ed9eba1;
    localparam logic [31:0] K2 = 32'h8f1bbcdc;
    localparam logic [31:0] K3 = 32'hca62c1d6;
    localparam logic [7:0]  IpadByte  = 8'h36;
    localparam logic [7:0]  OpadByte  = 8'h5c;
    localparam logic [7:0]  TruncMask = 8'h7f;

    typedef enum logic [2:0] {
        ST_IDLE, ST_IPAD, ST_OPAD, ST_INNER, ST_OUTER, ST_MOD, ST_DONE
    } t_state;

    typedef struct packed {
        logic         start;
        logic [159:0] init;
    } t_sha_req;

    typedef struct packed {
        logic         busy;
        logic         done;
        logic [159:0] hash;
    } t_sha_sts;

    // 10 to the power of the clamped digit count
    function automatic logic [29:0] pow10(input logic [3:0] digits);
        logic [29:0] v;
        case (digits)
            4'd0, 4'd1: v = 30'd10;
            4'd2:       v = 30'd100;
            4'd3:       v = 30'd1000;
            4'd4:       v = 30'd10000;
            4'd5:       v = 30'd100000;
            4'd6:       v = 30'd1000000;
            4'd7:       v = 30'd10000000;
            4'd8:       v = 30'd100000000;
            default:    v = 30'd1000000000;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/totp_sha_core.sv */
// SHA-1 compression of one 512-bit block; message schedule in a 16-word RAM.
// Depends on totp_pkg.
module totp_sha_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  totp_pkg::t_sha_req i_req,
    input  logic [511:0]       i_block,
    output totp_pkg::t_sha_sts o_sts
);
    import totp_pkg::*;

    logic [31:0]  mem [16];
    logic [31:0]  r_rd0, r_rd1, r_xa;
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [159:0] r_h, r_hash;
    logic [6:0]   r_rnd;
    logic [1:0]   r_phase;
    logic         r_busy, r_fin, r_done;

    logic [3:0]  w_ra0, w_ra1;
    logic [31:0] w_w, w_x, w_f, w_k, w_t;
    logic        w_step;
    logic [8:0]  w_base;

    assign w_base = {~r_rnd[3:0], 5'd0};
    assign w_x    = r_xa ^ r_rd0 ^ r_rd1;
    assign w_step = r_busy && ((r_rnd < 7'd16) || (r_phase == 2'd2));

    always_comb begin
        if (r_rnd < 7'd16) begin
            w_w = i_block[w_base +: 32];
        end else begin
            w_w = {w_x[30:0], w_x[31]};
        end
        if (r_phase == 2'd0) begin
            w_ra0 = r_rnd[3:0] + 4'd13;
            w_ra1 = r_rnd[3:0] + 4'd8;
        end else begin
            w_ra0 = r_rnd[3:0] + 4'd2;
            w_ra1 = r_rnd[3:0];
        end
        if (r_rnd < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K0;
        end else if (r_rnd < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K1;
        end else if (r_rnd < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K3;
        end
        w_t = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + w_w;
    end

    // schedule RAM: write current word, registered read of older words
    always_ff @(posedge i_clk) begin
        if (w_step) begin
            mem[r_rnd[3:0]] <= w_w;
        end
        r_rd0 <= mem[w_ra0];
        r_rd1 <= mem[w_ra1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_fin   <= 1'b0;
            r_done  <= 1'b0;
            r_rnd   <= '0;
            r_phase <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy  <= 1'b1;
                r_rnd   <= '0;
                r_phase <= '0;
                r_h     <= i_req.init;
                {r_a, r_b, r_c, r_d, r_e} <= i_req.init;
            end else if (r_fin) begin
                r_fin  <= 1'b0;
                r_done <= 1'b1;
                r_hash <= {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                           r_h[63:32] + r_d, r_h[31:0] + r_e};
            end else if (r_busy) begin
                if (w_step) begin
                    r_e     <= r_d;
                    r_d     <= r_c;
                    r_c     <= {r_b[1:0], r_b[31:2]};
                    r_b     <= r_a;
                    r_a     <= w_t;
                    r_phase <= '0;
                    if (r_rnd == 7'd79) begin
                        r_busy <= 1'b0;
                        r_fin  <= 1'b1;
                    end else begin
                        r_rnd <= r_rnd + 7'd1;
                    end
                end else if (r_phase == 2'd1) begin
                    r_xa    <= r_rd0 ^ r_rd1;
                    r_phase <= 2'd2;
                end else begin
                    r_phase <= 2'd1;
                end
            end
        end
    end

    assign o_sts.busy = r_busy || r_fin;
    assign o_sts.done = r_done;
    assign o_sts.hash = r_hash;

endmodule

/* hw/rtl/totp_mod_unit.sv */
// Restoring remainder unit: 31-bit value modulo a 30-bit divisor, one bit a cycle.
// Depends on totp_pkg for house style only.
module totp_mod_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [30:0] i_num,
    input  logic [29:0] i_div,
    output logic        o_done,
    output logic [29:0] o_rem
);
    import totp_pkg::*;

    logic [30:0] r_num;
    logic [29:0] r_rem;
    logic [4:0]  r_cnt;
    logic        r_busy, r_done;
    logic [30:0] w_trial, w_sub;

    assign w_trial = {r_rem, r_num[30]};
    assign w_sub   = w_trial - {1'b0, i_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start && !r_busy) begin
                r_busy <= 1'b1;
                r_num  <= i_num;
                r_rem  <= '0;
                r_cnt  <= 5'd30;
            end else if (r_busy) begin
                // keep the remainder below the divisor
                if (w_trial >= {1'b0, i_div}) begin
                    r_rem <= w_sub[29:0];
                end else begin
                    r_rem <= w_trial[29:0];
                end
                r_num <= {r_num[29:0], 1'b0};
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hw/rtl/totp_hmac_sha1_code_check.sv */
// Top level of the TOTP (HMAC-SHA1) code check: sequencer, config and handshakes.
// Depends on totp_pkg, totp_sha_core and totp_mod_unit.
//
//   channel  | direction | payload
//   s_axis   | in        | tdata: time_window[62:0], candidate_code[92:63]; tuser: candidate_valid
//   m_axis   | out       | tdata: code_value[29:0], accepted[30]
//   cfg      | in        | i_cfg_we, i_cfg_addr (register index), i_cfg_data
//
// One block compression runs a start, 16 load rounds, 64 rounds of three RAM phases each
// and a finish. An item with n windows (n = 2*skew+1 for a well-formed candidate,
// else 1) runs 2+2n compressions and n remainders after it is taken.
// Reset is synchronous and clears control and configuration; no memory sweep.
// A new word is taken only when the sequencer is idle; a finished result waits
// in the output register while the next word is taken.
module totp_hmac_sha1_code_check #(
    parameter int SECRET_BYTES = totp_pkg::SecretBytesDef
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [95:0]                   s_axis_tdata, // time_window, candidate_code
    input  logic [0:0]                    s_axis_tuser, // candidate_valid
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [31:0]                   m_axis_tdata, // code_value, accepted
    input  logic                          i_cfg_we,
    input  logic [totp_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [totp_pkg::CfgDataW-1:0] i_cfg_data
);
    import totp_pkg::*;

    localparam logic [191:0] KeyMask = ~(192'h0) << (192 - 8 * SECRET_BYTES);

    // configuration
    logic [63:0] r_sec_hi, r_sec_mid, r_sec_lo;
    logic [3:0]  r_digits;
    logic [1:0]  r_skew;

    // sequencer
    t_state       r_state, n_state;
    logic         r_issued, n_issued;
    logic [29:0]  r_cand;
    logic         r_cvalid;
    logic [63:0]  r_ctr;
    logic [2:0]   r_k, r_last, r_own;
    logic [159:0] r_hi, r_ho, r_inner;
    logic [30:0]  r_trunc;
    logic [29:0]  r_code;
    logic         r_ok;
    logic         r_out_valid;
    logic [29:0]  r_out_code;
    logic         r_out_ok;

    t_sha_req     w_req;
    t_sha_sts     w_sts;
    logic [511:0] w_block;
    logic [191:0] w_key;
    logic         w_mod_start, w_mod_done;
    logic [29:0]  w_rem;
    logic [7:0]   w_tbase;
    logic [31:0]  w_tword;
    logic         w_in_acc, w_load_out;

    assign w_key    = {r_sec_hi, r_sec_mid, r_sec_lo} & KeyMask;
    assign w_in_acc = s_axis_tvalid && s_axis_tready;
    // dynamic truncation: offset from the low nibble of the last digest byte
    assign w_tbase  = 8'd159 - {1'b0, w_sts.hash[3:0], 3'd0};
    assign w_tword  = w_sts.hash[w_tbase -: 32];

    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        w_req.start = 1'b0;
        w_req.init  = ShaIv;
        w_block     = {w_key ^ {24{IpadByte}}, {40{IpadByte}}};
        w_mod_start = 1'b0;
        w_load_out  = 1'b0;
        s_axis_tready = (r_state == ST_IDLE);
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_state  = ST_IPAD;
                    n_issued = 1'b0;
                end
            end
            ST_IPAD, ST_OPAD, ST_INNER, ST_OUTER: begin
                case (r_state)
                    ST_OPAD:  w_block = {w_key ^ {24{OpadByte}}, {40{OpadByte}}};
                    ST_INNER: begin
                        w_req.init = r_hi;
                        w_block    = {r_ctr, 8'h80, 376'd0, 64'd576};
                    end
                    ST_OUTER: begin
                        w_req.init = r_ho;
                        w_block    = {r_inner, 8'h80, 280'd0, 64'd672};
                    end
                    default: ;
                endcase
                w_req.start = !r_issued;
                n_issued    = 1'b1;
                if (r_issued && w_sts.done) begin
                    n_issued = 1'b0;
                    case (r_state)
                        ST_IPAD:  n_state = ST_OPAD;
                        ST_OPAD:  n_state = ST_INNER;
                        ST_INNER: n_state = ST_OUTER;
                        default:  n_state = ST_MOD;
                    endcase
                end
            end
            ST_MOD: begin
                w_mod_start = !r_issued;
                n_issued    = 1'b1;
                if (r_issued && w_mod_done) begin
                    n_issued = 1'b0;
                    n_state  = (r_k == r_last) ? ST_DONE : ST_INNER;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    w_load_out = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_issued    <= 1'b0;
            r_out_valid <= 1'b0;
            r_ok        <= 1'b0;
            r_k         <= '0;
            r_last      <= '0;
            r_sec_hi    <= '0;
            r_sec_mid   <= '0;
            r_sec_lo    <= '0;
            r_digits    <= 4'd6;
            r_skew      <= 2'd1;
        end else begin
            r_state  <= n_state;
            r_issued <= n_issued;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SECRET_HIGH:   r_sec_hi  <= i_cfg_data;
                    CFG_SECRET_MIDDLE: r_sec_mid <= i_cfg_data;
                    CFG_SECRET_LOW:    r_sec_lo  <= i_cfg_data;
                    CFG_DIGIT_COUNT:   r_digits  <= i_cfg_data[3:0];
                    CFG_SKEW_WINDOWS:  r_skew    <= i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                // well-formed candidates scan every window in the skew
                r_cand   <= s_axis_tdata[92:63];
                r_cvalid <= s_axis_tuser[0];
                r_ok     <= 1'b0;
                r_k      <= '0;
                if (s_axis_tuser[0]) begin
                    r_ctr  <= {1'b0, s_axis_tdata[62:0]} - {62'd0, r_skew};
                    r_last <= {r_skew, 1'b0};
                    r_own  <= {1'b0, r_skew};
                end else begin
                    r_ctr  <= {1'b0, s_axis_tdata[62:0]};
                    r_last <= '0;
                    r_own  <= '0;
                end
            end
            if (r_issued && w_sts.done) begin
                case (r_state)
                    ST_IPAD:  r_hi    <= w_sts.hash;
                    ST_OPAD:  r_ho    <= w_sts.hash;
                    ST_INNER: r_inner <= w_sts.hash;
                    ST_OUTER: r_trunc <= {w_tword[30:24] & TruncMask[6:0], w_tword[23:0]};
                    default: ;
                endcase
            end
            if (r_state == ST_MOD && r_issued && w_mod_done) begin
                if (r_k == r_own) begin
                    r_code <= w_rem;
                end
                if (r_cvalid && (w_rem == r_cand)) begin
                    r_ok <= 1'b1;
                end
                if (r_k != r_last) begin
                    r_k   <= r_k + 3'd1;
                    r_ctr <= r_ctr + 64'd1;
                end
            end
            // hold the result until taken
            if (w_load_out) begin
                r_out_valid <= 1'b1;
                r_out_code  <= r_code;
                r_out_ok    <= r_ok;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    totp_sha_core u_sha (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_block (w_block),
        .o_sts   (w_sts)
    );

    totp_mod_unit u_mod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_mod_start),
        .i_num   (r_trunc),
        .i_div   (pow10(r_digits)),
        .o_done  (w_mod_done),
        .o_rem   (w_rem)
    );

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0, r_out_ok, r_out_code};

    a_sha_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req.start |-> !w_sts.busy) else $error("hash start while busy");
    a_mod_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mod_done |-> r_state == ST_MOD) else $error("remainder outside its state");
    a_window_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state != ST_IDLE |-> r_k <= r_last) else $error("window index past range");
    a_bad_cand_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !r_cvalid) |-> !r_ok) else $error("bad candidate accepted");

endmodule

/* bench/totp_code_checker.sv */
// Checker for the TOTP code check block: follows register writes, predicts each
// result with its own HMAC-SHA1 and compares it with the output word. Uses totp_pkg.
module totp_code_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic [95:0]                   s_axis_tdata,
    input  logic [0:0]                    s_axis_tuser,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [31:0]                   m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [totp_pkg::CfgAddrW-1:0] i_cfg_addr,
    input  logic [totp_pkg::CfgDataW-1:0] i_cfg_data,
    output int                            o_fail_count,
    output int                            o_pending,
    output int                            o_hit_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import totp_pkg::*;

    typedef struct packed {
        logic [29:0] code_value;
        logic        accepted;
    } t_verdict;

    logic [63:0] key_high, key_middle, key_low;
    logic [3:0]  digits_reg;
    logic [1:0]  skew_reg;
    t_verdict    verdict_q[$];

    function automatic logic [159:0] hash_block(input logic [159:0] h,
                                                input logic [511:0] blk);
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = blk[511-32*i -: 32];
        for (int i = 16; i < 80; i++) begin
            t = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {t[30:0], t[31]};
        end
        {a, b, c, d, e} = h;
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d); k = K0;
            end else if (i < 40) begin
                f = b ^ c ^ d; k = K1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d); k = K2;
            end else begin
                f = b ^ c ^ d; k = K3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[i];
            e = d; d = c; c = {b[1:0], b[31:2]}; b = a; a = t;
        end
        return {h[159:128] + a, h[127:96] + b, h[95:64] + c, h[63:32] + d, h[31:0] + e};
    endfunction

    // Code for one counter under the current key and digit count.
    function automatic logic [29:0] window_code(input logic [63:0] counter);
        logic [511:0] key;
        logic [63:0]  low_mask;
        logic [159:0] inner, dig;
        logic [31:0]  trunc;
        logic [3:0]   digs;
        int           kept;
        kept = SecretBytesDef - 16;
        if (kept < 0) kept = 0;
        if (kept > 8) kept = 8;
        low_mask = (kept == 8) ? '1 : ~(64'hffff_ffff_ffff_ffff >> (8 * kept));
        key = {key_high, key_middle, key_low & low_mask, 320'b0};
        inner = hash_block(hash_block(ShaIv, key ^ {64{IpadByte}}),
                           {counter, 8'h80, 376'b0, 64'd576});
        dig = hash_block(hash_block(ShaIv, key ^ {64{OpadByte}}),
                         {inner, 8'h80, 280'b0, 64'd672});
        trunc = dig[159 - 8 * dig[3:0] -: 32];
        trunc[31] = 1'b0;
        digs = digits_reg;
        if (digs < 1) digs = 1;
        if (digs > 9) digs = 9;
        return 30'(trunc % 32'(pow10(digs)));
    endfunction

    function automatic t_verdict predict_verdict(input logic [62:0] window,
                                                 input logic [29:0] cand,
                                                 input logic        well_formed);
        t_verdict    v;
        logic [63:0] ctr;
        v.code_value = window_code({1'b0, window});
        v.accepted = 1'b0;
        if (well_formed) begin
            for (int k = 0; k <= 2 * skew_reg; k++) begin
                ctr = {1'b0, window} - 64'(skew_reg) + 64'(k);
                if (window_code(ctr) == cand) v.accepted = 1'b1;
            end
        end
        return v;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        o_fail_count++;
    endtask

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        o_hit_count = 0;
    end

    always @(posedge i_clk) begin
        t_verdict want, got;
        if (!i_rst_n) begin
            key_high = '0; key_middle = '0; key_low = '0;
            digits_reg = 4'd6; skew_reg = 2'd1;
            verdict_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_SECRET_HIGH:   key_high = i_cfg_data;
                    CFG_SECRET_MIDDLE: key_middle = i_cfg_data;
                    CFG_SECRET_LOW:    key_low = i_cfg_data;
                    CFG_DIGIT_COUNT:   digits_reg = i_cfg_data[3:0];
                    CFG_SKEW_WINDOWS:  skew_reg = i_cfg_data[1:0];
                    default: ;
                endcase
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[29:0], m_axis_tdata[30]};
                if (verdict_q.size() == 0) begin
                    report_mismatch("unexpected word", m_axis_tdata, 32'd0);
                end else begin
                    want = verdict_q.pop_front();
                    if (got.code_value !== want.code_value)
                        report_mismatch("code_value", 32'(got.code_value),
                                        32'(want.code_value));
                    if (got.accepted !== want.accepted)
                        report_mismatch("accepted", 32'(got.accepted), 32'(want.accepted));
                    if (want.accepted) o_hit_count++;
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                verdict_q.push_back(predict_verdict(s_axis_tdata[62:0],
                                                    s_axis_tdata[92:63], s_axis_tuser[0]));
        end
        o_pending = verdict_q.size();
    end

endmodule

/* bench/testbench.sv */
// Top of the TOTP code check bench: clock, reset, register setup, stimulus and verdict.
// Depends on totp_pkg, totp_hmac_sha1_code_check and totp_code_checker.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import totp_pkg::*;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [95:0]         s_axis_tdata = '0;   // time_window[62:0], candidate_code[92:63]
    logic [0:0]          s_axis_tuser = '0;   // candidate_valid
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [31:0]         m_axis_tdata;        // code_value[29:0], accepted[30]
    logic                i_cfg_we = 1'b0;
    logic [CfgAddrW-1:0] i_cfg_addr = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    int   fail_count, pending, hit_count;
    int   words_sent = 0;
    bit   idle_on = 1'b1;   // random gaps and stalls; cleared for the last phase
    logic [1:0] cur_skew = 2'd1;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    totp_hmac_sha1_code_check dut (.*);

    totp_code_checker u_chk (
        .*,
        .o_fail_count(fail_count),
        .o_pending(pending),
        .o_hit_count(hit_count)
    );

    // Output side: hold tready low for random bursts while idling is on.
    always begin
        @(posedge i_clk);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        m_axis_tready <= 1'b1;
    end

    // Write one register; caller lowers the enable once a group is done.
    task automatic cfg_write(input logic [CfgAddrW-1:0] idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx == CFG_SKEW_WINDOWS) cur_skew = val[1:0];
    endtask

    // Drop the input, drain outstanding results, then load a full register set.
    task automatic load_setting(input logic [63:0] hi, input logic [63:0] mid,
                                input logic [63:0] lo, input logic [3:0] digs,
                                input logic [1:0] skew);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        cfg_write(CFG_SECRET_HIGH, hi);
        cfg_write(CFG_SECRET_MIDDLE, mid);
        cfg_write(CFG_SECRET_LOW, lo);
        cfg_write(CFG_DIGIT_COUNT, 64'(digs));
        cfg_write(CFG_SKEW_WINDOWS, 64'(skew));
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Offer one word, wait for the handshake, then maybe idle a burst.
    task automatic send_word(input logic [62:0] window, input logic [29:0] cand,
                             input logic ok);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {3'b0, cand, window};
        s_axis_tuser <= ok;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        words_sent++;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
    endtask

    // Code of a window shifted by off, with wrap at 2^64.
    function automatic logic [29:0] shifted_code(input logic [62:0] window, input int off);
        return u_chk.window_code({1'b0, window} + 64'(signed'(off)));
    endfunction

    task automatic random_word();
        logic [62:0] window;
        logic [29:0] cand;
        int          off;
        case ($urandom_range(0, 3))
            0:       window = 63'($urandom_range(0, 4));
            1:       window = '1 - 63'($urandom_range(0, 4));
            default: window = 63'({$urandom, $urandom});
        endcase
        if ($urandom_range(0, 9) < 6) begin
            // well-formed guess, sometimes just outside the skew
            off = $urandom_range(0, 2 * cur_skew + 2) - cur_skew - 1;
            cand = shifted_code(window, off);
        end else begin
            cand = 30'($urandom);
        end
        send_word(window, cand, $urandom_range(0, 9) != 0);
    endtask

    initial begin
        logic [62:0] w;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: reset settings (zero key, 6 digits, skew 1), window zero wraps.
        send_word('0, shifted_code('0, -1), 1'b1);
        send_word('0, shifted_code('0, 0), 1'b1);
        send_word('1, shifted_code('1, 1), 1'b1);

        // Known test key "12345678901234567890", 8 digits, skew 1.
        load_setting(64'h3132333435363738, 64'h3930313233343536,
                     64'h37383930_ffffffff, 4'd8, 2'd1);
        w = 63'd59 / 30;
        send_word(w, shifted_code(w, 0), 1'b1);
        send_word(w, shifted_code(w, 1), 1'b1);
        send_word(w, shifted_code(w, -1), 1'b1);
        send_word(w, shifted_code(w, 2), 1'b1);       // just outside the skew
        send_word(w, shifted_code(w, 0), 1'b0);       // not well formed
        send_word(w, 30'h3fffffff, 1'b1);             // out of range, flagged valid
        send_word(63'h2aaaaaaaaaaaaaaa, '0, 1'b1);
        send_word(63'h5555555555555555, 30'h15555555, 1'b1);

        // Digit count clamping (0 acts as 1, 15 as 9), skew extremes.
        load_setting('1, '1, '1, 4'd0, 2'd0);
        send_word('0, shifted_code('0, 0), 1'b1);
        send_word('1, shifted_code('1, 0), 1'b1);
        load_setting('0, '0, '0, 4'd15, 2'd3);
        send_word('0, shifted_code('0, -3), 1'b1);
        send_word('1, shifted_code('1, 3), 1'b1);
        send_word(63'd1, shifted_code(63'd1, -4), 1'b1);

        // Random phases over a spread of settings, last one without idling.
        for (int ph = 0; ph < 8; ph++) begin
            logic [3:0] digs;
            case (ph)
                0:       digs = 4'd1;
                1:       digs = 4'd9;
                2:       digs = 4'd6;
                default: digs = 4'($urandom_range(0, 15));
            endcase
            load_setting({$urandom, $urandom}, {$urandom, $urandom},
                         {$urandom, $urandom}, digs, 2'(ph % 4));
            if (ph == 7) idle_on = 1'b0;
            repeat (65) random_word();
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        while (pending != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("Checked %0d words over twelve register settings, %0d accepted candidates.",
                 words_sent, hit_count);
        $display("Covered key and digit extremes, skew 0 to 3, wrap at window zero.");
        if (fail_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // Guard: far beyond the slowest legal run.
    initial begin
        #50ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
